FILE: src/next_pc_branch_target_unit_assert.svh
// Assertion helpers for the next-PC unit.
// Both expect clk and the active-low rst_n in the scope where they are used.
`ifndef NEXT_PC_BRANCH_TARGET_UNIT_ASSERT_SVH
`define NEXT_PC_BRANCH_TARGET_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NPBT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("next-pc unit: same-cycle check failed");

// Next-cycle implication.
`define NPBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-pc unit: next-cycle check failed");

`endif

FILE: src/npbt_pkg.sv
// ----------------------------------------------------------------------------
// npbt_pkg
// Beat types, flow codes and opcode patterns for the next-PC unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npbt_pkg;

    // Kind of control transfer reported with each result
    typedef enum logic [2:0] {
        FLOW_SEQ      = 3'd0,
        FLOW_COND     = 3'd1,
        FLOW_PC_DISP  = 3'd2,
        FLOW_PC_REG   = 3'd3,
        FLOW_REG_JUMP = 3'd4,
        FLOW_RTS      = 3'd5,
        FLOW_RTE      = 3'd6,
        FLOW_TRAP     = 3'd7
    } flow_kind_t;

    // Input beat
    typedef struct packed {
        logic [15:0] opcode;
        logic [31:0] pc;
        logic        t_flag;
        logic [31:0] reg_value;
        logic [31:0] return_addr;
        logic [31:0] stack_word;
        logic [31:0] vector_word;
    } npbt_in_t;

    // Result beat
    typedef struct packed {
        logic [31:0] next_addr;
        flow_kind_t  flow_kind;
    } npbt_out_t;

    // Opcode field masks
    localparam logic [15:0] MASK_HI8 = 16'hFF00;
    localparam logic [15:0] MASK_HI4 = 16'hF000;
    localparam logic [15:0] MASK_PAT = 16'hF0FF;

    // Conditional branches
    localparam logic [15:0] OP_BT    = 16'h8900;
    localparam logic [15:0] OP_BTS   = 16'h8D00;
    localparam logic [15:0] OP_BF    = 16'h8B00;
    localparam logic [15:0] OP_BFS   = 16'h8F00;
    // Displacement branches
    localparam logic [15:0] OP_BRA   = 16'hA000;
    localparam logic [15:0] OP_BSR   = 16'hB000;
    // Register-relative and register jumps
    localparam logic [15:0] OP_BRAF  = 16'h0023;
    localparam logic [15:0] OP_BSRF  = 16'h0003;
    localparam logic [15:0] OP_JMP   = 16'h402B;
    localparam logic [15:0] OP_JSR   = 16'h400B;
    // Returns and trap
    localparam logic [15:0] OP_RTS   = 16'h000B;
    localparam logic [15:0] OP_RTE   = 16'h002B;
    localparam logic [15:0] OP_TRAPA = 16'hC300;

endpackage

FILE: src/next_pc_branch_target_unit.sv
// A result passes through the s1, s2 and s3 registers in turn and is offered
// from s3, which it leaves once result_stall is low.
// Throughput: one item per cycle while result_stall is low; decode, operand
// select and the final add are one register stage each. A stalled output holds
// only its own stage, and earlier stages keep moving until the bubbles ahead of them are filled.
// Reset: rst_n clears all stage valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
// next_pc_branch_target_unit
// Three-stage next-address calculator for 16-bit branch instructions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "next_pc_branch_target_unit_assert.svh"

module next_pc_branch_target_unit
    import npbt_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  npbt_in_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output npbt_out_t result
);

    localparam int AW = ADDR_WIDTH;
    localparam logic [AW-1:0] STEP_SEQ    = AW'(2);
    localparam logic [AW-1:0] STEP_BRANCH = AW'(4);

    // Zero-extend or cut a 32-bit value to the address width
    function automatic logic [AW-1:0] to_addr(input logic [31:0] v);
        logic [AW+31:0] wide;
        wide = {{AW{1'b0}}, v};
        return wide[AW-1:0];
    endfunction

    // Stage registers
    logic            s1_valid_reg, s1_valid_next;
    npbt_in_t        s1_item_reg;
    flow_kind_t      s1_kind_reg;
    logic            s2_valid_reg, s2_valid_next;
    logic [AW-1:0]   s2_base_reg, s2_base_next;
    logic [AW-1:0]   s2_addend_reg, s2_addend_next;
    flow_kind_t      s2_kind_reg;
    logic            s3_valid_reg, s3_valid_next;
    npbt_out_t       s3_result_reg, s3_result_next;

    logic            s1_adv, s2_adv, s3_adv;
    flow_kind_t      dec_kind;
    logic [15:0]     hi8, hi4, pat;
    logic [AW-1:0]   disp8, disp12;
    logic [AW-1:0]   sum;
    logic [AW+31:0]  sum_ext;

    // Stage advance: a stage loads when it is empty or its successor moves
    always_comb
    begin
        s3_adv = !s3_valid_reg || !result_stall;
        s2_adv = !s2_valid_reg || s3_adv;
        s1_adv = !s1_valid_reg || s2_adv;
    end

    assign item_stall   = !s1_adv;
    assign result_valid = s3_valid_reg;
    assign result       = s3_result_reg;

    // Decode of the incoming opcode, first match wins
    always_comb
    begin
        hi8 = item.opcode & MASK_HI8;
        hi4 = item.opcode & MASK_HI4;
        pat = item.opcode & MASK_PAT;
        priority if (((hi8 == OP_BT) || (hi8 == OP_BTS)) && item.t_flag)
            dec_kind = FLOW_COND;
        else if (((hi8 == OP_BF) || (hi8 == OP_BFS)) && !item.t_flag)
            dec_kind = FLOW_COND;
        else if ((hi4 == OP_BRA) || (hi4 == OP_BSR))
            dec_kind = FLOW_PC_DISP;
        else if ((pat == OP_BRAF) || (pat == OP_BSRF))
            dec_kind = FLOW_PC_REG;
        else if ((pat == OP_JMP) || (pat == OP_JSR))
            dec_kind = FLOW_REG_JUMP;
        else if (item.opcode == OP_RTS)
            dec_kind = FLOW_RTS;
        else if (item.opcode == OP_RTE)
            dec_kind = FLOW_RTE;
        else if (hi8 == OP_TRAPA)
            dec_kind = FLOW_TRAP;
        else
            dec_kind = FLOW_SEQ;
    end

    // Operand select: result is base + addend
    always_comb
    begin
        disp8  = {{(AW-9){s1_item_reg.opcode[7]}}, s1_item_reg.opcode[7:0], 1'b0};
        disp12 = {{(AW-13){s1_item_reg.opcode[11]}}, s1_item_reg.opcode[11:0], 1'b0};
        s2_base_next   = to_addr(s1_item_reg.pc);
        s2_addend_next = STEP_SEQ;
        unique case (s1_kind_reg)
            FLOW_SEQ:      s2_addend_next = STEP_SEQ;
            FLOW_COND:     s2_addend_next = STEP_BRANCH + disp8;
            FLOW_PC_DISP:  s2_addend_next = STEP_BRANCH + disp12;
            FLOW_PC_REG:   s2_addend_next = STEP_BRANCH + to_addr(s1_item_reg.reg_value);
            FLOW_REG_JUMP:
            begin
                s2_base_next   = '0;
                s2_addend_next = to_addr(s1_item_reg.reg_value);
            end
            FLOW_RTS:
            begin
                s2_base_next   = '0;
                s2_addend_next = to_addr(s1_item_reg.return_addr);
            end
            FLOW_RTE:
            begin
                s2_base_next   = '0;
                s2_addend_next = to_addr(s1_item_reg.stack_word);
            end
            FLOW_TRAP:
            begin
                s2_base_next   = '0;
                s2_addend_next = to_addr(s1_item_reg.vector_word);
            end
        endcase
    end

    // Final add, wrapped to the address width and zero-extended or cut to 32 bits
    always_comb
    begin
        sum     = s2_base_reg + s2_addend_reg;
        sum_ext = {32'd0, sum};
        s3_result_next.next_addr = sum_ext[31:0];
        s3_result_next.flow_kind = s2_kind_reg;
    end

    // Valid bits
    always_comb
    begin
        s1_valid_next = s1_adv ? item_valid   : s1_valid_reg;
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_adv ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Data registers, loaded only when a beat moves in
    always_ff @(posedge clk)
    begin
        if (s1_adv && item_valid)
        begin
            s1_item_reg <= item;
            s1_kind_reg <= dec_kind;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_base_reg   <= s2_base_next;
            s2_addend_reg <= s2_addend_next;
            s2_kind_reg   <= s1_kind_reg;
        end
        if (s3_adv && s2_valid_reg)
        begin
            s3_result_reg <= s3_result_next;
        end
    end

    // Checks
    `NPBT_ASSERT_NOW(a_stall_needs_full_front, item_stall, s1_valid_reg && s2_valid_reg && s3_valid_reg)
    `NPBT_ASSERT_NEXT(a_s2_holds_when_blocked, s2_valid_reg && !s3_adv, s2_valid_reg && $stable(s2_base_reg) && $stable(s2_addend_reg))
    `NPBT_ASSERT_NOW(a_rts_decode, s1_valid_reg && (s1_kind_reg == FLOW_RTS), s1_item_reg.opcode == OP_RTS)
    `NPBT_ASSERT_NOW(a_absolute_has_no_base, s2_valid_reg && (s2_kind_reg == FLOW_REG_JUMP || s2_kind_reg == FLOW_RTS || s2_kind_reg == FLOW_RTE || s2_kind_reg == FLOW_TRAP), s2_base_reg == '0)

endmodule
